### sv/rrcd_pkg.sv
// Shared types and constants for the round-robin CPU dispatcher.
// No dependencies; every other file of the block refers to this package.
package rrcd_pkg;

  localparam int MAX_CPUS_DEF    = 8;
  localparam int QUEUE_DEPTH_DEF = 16;

  localparam int TAG_W    = 16;
  localparam int SLOT_IN_W = 4;
  localparam int WORD_W   = 32;
  localparam int ACTIVE_W = 4;
  localparam int KIND_W   = 3;
  localparam int CPU_OUT_W = 3;
  // wide enough for any CPU count up to sixteen
  localparam int NCPU_W   = 5;

  localparam logic [WORD_W-1:0]   TIME_REMAIN_NS    = WORD_W'(100);
  localparam logic [ACTIVE_W-1:0] ACTIVE_CPUS_RESET = ACTIVE_W'(8);
  localparam logic [WORD_W-1:0]   TIME_SLICE_RESET  = WORD_W'(1000);

  localparam int CFG_INDEX_W = 1;
  localparam logic [CFG_INDEX_W-1:0] REG_ACTIVE_CPUS = 1'b0;
  localparam logic [CFG_INDEX_W-1:0] REG_TIME_SLICE  = 1'b1;

  typedef enum logic [KIND_W-1:0] {
    KIND_DISPATCH = 3'd0,
    KIND_COMPLETE = 3'd1,
    KIND_QUEUED   = 3'd2,
    KIND_BAD_CPU  = 3'd3,
    KIND_OVERFLOW = 3'd4
  } kind_t;

  typedef struct packed {
    kind_t                  kind;
    logic [TAG_W-1:0]       tag;
    logic [CPU_OUT_W-1:0]   cpu;
    logic [WORD_W-1:0]      slice;
    logic                   last;
  } result_t;

  typedef struct packed {
    logic capture;   // latch the incoming job
    logic process;   // update scheduler state and build results
    logic sel;       // present second result
  } cmd_t;

  typedef struct packed {
    logic two;       // current item has two results
  } status_t;

endpackage

### sv/rrcd_if.sv
// Valid/ready channel interfaces for jobs in and results out.
// Depends on rrcd_pkg for field widths.
interface rrcd_in_if;
  logic                            valid;
  logic                            ready;
  logic                            opcode;
  logic [rrcd_pkg::TAG_W-1:0]      job_tag;
  logic [rrcd_pkg::SLOT_IN_W-1:0]  cpu_slot;
  logic [rrcd_pkg::WORD_W-1:0]     instr_left;
  logic [rrcd_pkg::WORD_W-1:0]     time_left_ns;

  modport source (output valid, opcode, job_tag, cpu_slot, instr_left, time_left_ns,
                  input ready);
  modport sink   (input valid, opcode, job_tag, cpu_slot, instr_left, time_left_ns,
                  output ready);
endinterface

interface rrcd_out_if;
  logic                            valid;
  logic                            ready;
  logic [rrcd_pkg::KIND_W-1:0]     kind;
  logic [rrcd_pkg::TAG_W-1:0]      job_tag_out;
  logic [rrcd_pkg::CPU_OUT_W-1:0]  target_cpu;
  logic [rrcd_pkg::WORD_W-1:0]     slice_out;
  logic                            last_result;

  modport source (output valid, kind, job_tag_out, target_cpu, slice_out, last_result,
                  input ready);
  modport sink   (input valid, kind, job_tag_out, target_cpu, slice_out, last_result,
                  output ready);
endinterface

### sv/round_robin_cpu_dispatcher.sv
// Round-robin CPU dispatcher, top level: controller plus datapath.
// After a job transfer the controller passes through a process state and then presents
// the first result; a second result, if any, is presented once the first transfers.
// Jobs do not overlap: a new job is taken only after the last result of the previous one,
// set by the controller sequence capture, process, send; back-pressure on results stalls it.
// Reset (rst, synchronous): all CPUs idle, wait queue empty, active_cpus 8,
// time_slice 1000; no clearing pass, the block takes jobs the cycle after reset.
module round_robin_cpu_dispatcher #(
  parameter int MAX_CPUS    = rrcd_pkg::MAX_CPUS_DEF,
  parameter int QUEUE_DEPTH = rrcd_pkg::QUEUE_DEPTH_DEF
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_write,
  input  logic [rrcd_pkg::CFG_INDEX_W-1:0]  cfg_index,
  input  logic [rrcd_pkg::WORD_W-1:0]       cfg_data,
  rrcd_in_if.sink                           jobs,
  rrcd_out_if.source                        results
);

  rrcd_pkg::cmd_t    cmd;
  rrcd_pkg::status_t status;

  rrcd_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (jobs.valid),
    .in_ready  (jobs.ready),
    .out_valid (results.valid),
    .out_ready (results.ready),
    .cmd       (cmd),
    .status    (status)
  );

  rrcd_dpath #(
    .MAX_CPUS    (MAX_CPUS),
    .QUEUE_DEPTH (QUEUE_DEPTH)
  ) u_dpath (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .status       (status),
    .cfg_write    (cfg_write),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .opcode       (jobs.opcode),
    .job_tag      (jobs.job_tag),
    .cpu_slot     (jobs.cpu_slot),
    .instr_left   (jobs.instr_left),
    .time_left_ns (jobs.time_left_ns),
    .kind         (results.kind),
    .job_tag_out  (results.job_tag_out),
    .target_cpu   (results.target_cpu),
    .slice_out    (results.slice_out),
    .last_result  (results.last_result)
  );

endmodule

### sv/rrcd_ctrl.sv
// Sequencing controller: accept a job, process it, deliver one or two results.
// Depends on rrcd_pkg (cmd_t, status_t).
module rrcd_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  output logic              out_valid,
  input  logic              out_ready,
  output rrcd_pkg::cmd_t    cmd,
  input  rrcd_pkg::status_t status
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_PROC,
    S_SEND0,
    S_SEND1
  } state_t;

  state_t state;
  logic   ready;
  logic   valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      ready <= 1'b1;
      valid <= 1'b0;
    end else begin
      case (state)
        S_IDLE: begin
          if (in_valid && ready) begin
            state <= S_PROC;
            ready <= 1'b0;
          end
        end
        S_PROC: begin
          state <= S_SEND0;
          valid <= 1'b1;
        end
        S_SEND0: begin
          if (out_ready) begin
            if (status.two) begin
              state <= S_SEND1;
            end else begin
              state <= S_IDLE;
              valid <= 1'b0;
              ready <= 1'b1;
            end
          end
        end
        S_SEND1: begin
          if (out_ready) begin
            state <= S_IDLE;
            valid <= 1'b0;
            ready <= 1'b1;
          end
        end
        default: begin
          state <= S_IDLE;
          valid <= 1'b0;
          ready <= 1'b1;
        end
      endcase
    end
  end

  assign in_ready    = ready;
  assign out_valid   = valid;
  assign cmd.capture = in_valid && ready;
  assign cmd.process = (state == S_PROC);
  assign cmd.sel     = (state == S_SEND1);

  a_no_overlap: assert property (@(posedge clk) disable iff (rst)
    !(ready && valid))
    else $error("input accepted while a result is pending");

  a_proc_then_send: assert property (@(posedge clk) disable iff (rst)
    cmd.process |=> valid && !ready)
    else $error("no result after processing");

  a_capture_then_proc: assert property (@(posedge clk) disable iff (rst)
    cmd.capture |=> cmd.process)
    else $error("captured job not processed");

endmodule

### sv/rrcd_dpath.sv
// Scheduler datapath: config registers, idle mask, wait FIFO, result registers.
// Depends on rrcd_pkg; driven by rrcd_ctrl through cmd_t / status_t.
module rrcd_dpath #(
  parameter int MAX_CPUS    = rrcd_pkg::MAX_CPUS_DEF,
  parameter int QUEUE_DEPTH = rrcd_pkg::QUEUE_DEPTH_DEF
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  rrcd_pkg::cmd_t                       cmd,
  output rrcd_pkg::status_t                    status,
  input  logic                                 cfg_write,
  input  logic [rrcd_pkg::CFG_INDEX_W-1:0]     cfg_index,
  input  logic [rrcd_pkg::WORD_W-1:0]          cfg_data,
  input  logic                                 opcode,
  input  logic [rrcd_pkg::TAG_W-1:0]           job_tag,
  input  logic [rrcd_pkg::SLOT_IN_W-1:0]       cpu_slot,
  input  logic [rrcd_pkg::WORD_W-1:0]          instr_left,
  input  logic [rrcd_pkg::WORD_W-1:0]          time_left_ns,
  output logic [rrcd_pkg::KIND_W-1:0]          kind,
  output logic [rrcd_pkg::TAG_W-1:0]           job_tag_out,
  output logic [rrcd_pkg::CPU_OUT_W-1:0]       target_cpu,
  output logic [rrcd_pkg::WORD_W-1:0]          slice_out,
  output logic                                 last_result
);

  localparam int PICK_W = (MAX_CPUS > 1) ? $clog2(MAX_CPUS) : 1;
  localparam int PTR_W  = $clog2(QUEUE_DEPTH);
  localparam int CNT_W  = $clog2(QUEUE_DEPTH + 1);
  localparam logic [PTR_W-1:0]   PTR_LAST = PTR_W'(QUEUE_DEPTH - 1);
  localparam logic [CNT_W-1:0]   CNT_FULL = CNT_W'(QUEUE_DEPTH);
  localparam logic [MAX_CPUS-1:0] ONE_HOT0 = MAX_CPUS'(1);

  // configuration
  logic [rrcd_pkg::ACTIVE_W-1:0] active_cpus;
  logic [rrcd_pkg::WORD_W-1:0]   time_slice;

  // scheduler state
  logic [MAX_CPUS-1:0] idle_mask;
  logic [PTR_W-1:0]    head_ptr;
  logic [PTR_W-1:0]    tail_ptr;
  logic [CNT_W-1:0]    wait_count;
  logic [rrcd_pkg::TAG_W-1:0] wait_store [QUEUE_DEPTH];
  logic [rrcd_pkg::TAG_W-1:0] head_data;

  // captured job
  logic                           opcode_q;
  logic [rrcd_pkg::TAG_W-1:0]     tag_q;
  logic [rrcd_pkg::SLOT_IN_W-1:0] slot_q;
  logic [rrcd_pkg::WORD_W-1:0]    instr_q;
  logic [rrcd_pkg::WORD_W-1:0]    tleft_q;

  rrcd_pkg::result_t res0, res1;
  logic              two;

  // processing terms
  logic [rrcd_pkg::NCPU_W-1:0] n_use;
  logic [MAX_CPUS-1:0]  use_mask;
  logic                 any_idle;
  logic [PICK_W-1:0]    pick;
  logic                 slot_ok;
  logic                 requeue;
  logic                 do_push;
  logic                 push_ok;
  logic [CNT_W-1:0]     cnt_push;
  logic                 do_pop;
  logic [rrcd_pkg::TAG_W-1:0] pop_tag;
  logic [MAX_CPUS-1:0]  idle_mask_next;
  logic [CNT_W-1:0]     wait_count_next;
  logic [PTR_W-1:0]     head_ptr_next;
  logic [PTR_W-1:0]     tail_ptr_next;
  rrcd_pkg::result_t    mid_res, res0_next, res1_next;
  logic                 two_next;

  always_comb begin
    if ({1'b0, active_cpus} > rrcd_pkg::NCPU_W'(MAX_CPUS)) begin
      n_use = rrcd_pkg::NCPU_W'(MAX_CPUS);
    end else begin
      n_use = {1'b0, active_cpus};
    end

    for (int i = 0; i < MAX_CPUS; i++) begin
      use_mask[i] = idle_mask[i] && (rrcd_pkg::NCPU_W'(i) < n_use);
    end
    any_idle = |use_mask;

    // lowest-numbered idle CPU
    pick = '0;
    for (int i = MAX_CPUS - 1; i >= 0; i--) begin
      if (use_mask[i]) begin
        pick = PICK_W'(i);
      end
    end

    slot_ok  = {1'b0, slot_q} < n_use;
    requeue  = (instr_q != '0) || (tleft_q > rrcd_pkg::TIME_REMAIN_NS);
    do_push  = opcode_q ? requeue : !any_idle;
    push_ok  = do_push && (wait_count < CNT_FULL);
    cnt_push = wait_count + CNT_W'(push_ok);
    do_pop   = opcode_q && slot_ok && (cnt_push != '0);
    // a job pushed into an empty queue is its own head
    pop_tag  = (wait_count == '0) ? tag_q : head_data;

    wait_count_next = cnt_push - CNT_W'(do_pop);
    tail_ptr_next   = tail_ptr;
    if (push_ok) begin
      tail_ptr_next = (tail_ptr == PTR_LAST) ? '0 : tail_ptr + PTR_W'(1);
    end
    head_ptr_next = head_ptr;
    if (do_pop) begin
      head_ptr_next = (head_ptr == PTR_LAST) ? '0 : head_ptr + PTR_W'(1);
    end

    idle_mask_next = idle_mask;
    if (!opcode_q) begin
      if (any_idle) begin
        idle_mask_next = idle_mask & ~(ONE_HOT0 << pick);
      end
    end else if (slot_ok) begin
      if (do_pop) begin
        // freed CPU goes busy again at once with the queue head
        idle_mask_next = idle_mask & ~(ONE_HOT0 << slot_q);
      end else begin
        idle_mask_next = idle_mask | (ONE_HOT0 << slot_q);
      end
    end

    mid_res       = '0;
    mid_res.tag   = tag_q;
    if (do_push) begin
      mid_res.kind = push_ok ? rrcd_pkg::KIND_QUEUED : rrcd_pkg::KIND_OVERFLOW;
    end else begin
      mid_res.kind = rrcd_pkg::KIND_COMPLETE;
    end

    res0_next = mid_res;
    res1_next = '0;
    two_next  = 1'b0;
    if (!opcode_q) begin
      if (any_idle) begin
        res0_next.kind  = rrcd_pkg::KIND_DISPATCH;
        res0_next.cpu   = rrcd_pkg::CPU_OUT_W'(pick);
        res0_next.slice = time_slice;
      end
    end else if (!slot_ok) begin
      res0_next      = '0;
      res0_next.kind = rrcd_pkg::KIND_BAD_CPU;
      res0_next.tag  = tag_q;
      res1_next      = mid_res;
      two_next       = 1'b1;
    end else if (do_pop) begin
      res1_next.kind  = rrcd_pkg::KIND_DISPATCH;
      res1_next.tag   = pop_tag;
      res1_next.cpu   = rrcd_pkg::CPU_OUT_W'(slot_q);
      res1_next.slice = time_slice;
      two_next        = 1'b1;
    end
    res0_next.last = !two_next;
    res1_next.last = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      active_cpus <= rrcd_pkg::ACTIVE_CPUS_RESET;
      time_slice  <= rrcd_pkg::TIME_SLICE_RESET;
      idle_mask   <= '1;
      head_ptr    <= '0;
      tail_ptr    <= '0;
      wait_count  <= '0;
    end else begin
      if (cfg_write) begin
        case (cfg_index)
          rrcd_pkg::REG_ACTIVE_CPUS: active_cpus <= cfg_data[rrcd_pkg::ACTIVE_W-1:0];
          rrcd_pkg::REG_TIME_SLICE:  time_slice  <= cfg_data;
          default: ;
        endcase
      end
      if (cmd.process) begin
        idle_mask  <= idle_mask_next;
        head_ptr   <= head_ptr_next;
        tail_ptr   <= tail_ptr_next;
        wait_count <= wait_count_next;
      end
    end
  end

  // wait FIFO storage, registered head read
  always_ff @(posedge clk) begin
    if (cmd.process && push_ok) begin
      wait_store[tail_ptr] <= tag_q;
    end
    head_data <= wait_store[head_ptr];
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      opcode_q <= opcode;
      tag_q    <= job_tag;
      slot_q   <= cpu_slot;
      instr_q  <= instr_left;
      tleft_q  <= time_left_ns;
    end
    if (cmd.process) begin
      res0 <= res0_next;
      res1 <= res1_next;
      two  <= two_next;
    end
  end

  rrcd_pkg::result_t res_sel;
  assign res_sel     = cmd.sel ? res1 : res0;
  assign kind        = res_sel.kind;
  assign job_tag_out = res_sel.tag;
  assign target_cpu  = res_sel.cpu;
  assign slice_out   = res_sel.slice;
  assign last_result = res_sel.last;
  assign status.two  = two;

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    wait_count <= CNT_FULL)
    else $error("wait count beyond queue depth");

  a_empty_ptrs: assert property (@(posedge clk) disable iff (rst)
    wait_count == '0 |-> head_ptr == tail_ptr)
    else $error("empty queue with unequal pointers");

  a_bad_cpu_mask: assert property (@(posedge clk) disable iff (rst)
    cmd.process && opcode_q && !slot_ok |=> idle_mask == $past(idle_mask))
    else $error("bad cpu index changed the idle mask");

endmodule
